/* src/pff_pkg.sv */
// Shared types, codes and helper functions of the potential field force pipeline.
package pff_pkg;

    localparam int POS_W  = 16;
    localparam int DIF_W  = 17;
    localparam int MAG_W  = 16;
    localparam int CFG_W  = 32;
    localparam int FRC_W  = 32;
    localparam int ACC_W  = 64;
    localparam int NUM_REGS = 8;

    typedef enum logic [2:0] {
        ACT_LINES_RIGHT   = 3'd0,
        ACT_LINES_LEFT    = 3'd1,
        ACT_RIVAL_REPEL   = 3'd2,
        ACT_RIVAL_ATTRACT = 3'd3,
        ACT_BALL_ATTRACT  = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        REG_LEFT_GOAL  = 3'd0,
        REG_RIGHT_GOAL = 3'd1,
        REG_LINES_X    = 3'd2,
        REG_LINES_Y    = 3'd3,
        REG_LINE_GAIN  = 3'd4,
        REG_GOAL_GAIN  = 3'd5,
        REG_RIVAL_GAIN = 3'd6,
        REG_BALL_GAIN  = 3'd7
    } t_reg;

    typedef struct packed {
        logic       main_en;
        logic       sgn_x;
        logic       sgn_y;
        logic [3:0] line_en;
        logic [3:0] line_sgn;
    } t_flags;

    typedef struct packed {
        logic              pt;
        logic [CFG_W-1:0]  gmag;
        logic [MAG_W-1:0]  ax;
        logic [MAG_W-1:0]  ay;
    } t_mulop;

    function automatic logic [MAG_W-1:0] mag17(input logic [DIF_W-1:0] v);
        logic [DIF_W-1:0] t;
        t = v[DIF_W-1] ? (~v + 17'd1) : v;
        return t[MAG_W-1:0];
    endfunction

    function automatic logic [CFG_W-1:0] mag32(input logic [CFG_W-1:0] v);
        return v[CFG_W-1] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [ACC_W-1:0] signed_term(input logic en, input logic sgn,
                                                     input logic [ACC_W-2:0] m);
        logic [ACC_W-1:0] t;
        t = {1'b0, m};
        if (!en) begin
            return '0;
        end
        return sgn ? (~t + 64'd1) : t;
    endfunction

endpackage

/* src/potential_field_force.sv */
// Top level of the potential field force pipeline with its register file.
// Each beat on the input stream is one field evaluation and gives one force beat; a
// new beat is taken in every cycle unless the output stalls. The depth is set by the
// 63-stage restoring divider that forms the goal and point terms, after a 25-stage
// square root and a 31-stage divider for the inverse-square factor. While a result
// waits on the output, the whole pipeline holds and s_axis_tready is low.
module potential_field_force (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // pos_x, pos_y, other_x, other_y
    input  logic [2:0]  s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // force_x, force_y
    output logic        m_axis_tuser   // saturated
);
    localparam int ROOT_W = 25;
    localparam int S_W    = 33;
    localparam int BX_QW  = 31;
    localparam int BX_NW  = pff_pkg::MAG_W + BX_QW;
    localparam int LN_NW  = pff_pkg::CFG_W + 8;
    localparam int M_NW   = 63;
    localparam int M_DW   = 32;
    localparam int T_S    = 3;
    localparam int T_ROOT = T_S + ROOT_W;
    localparam int T_BX   = T_S + BX_QW;
    localparam int T_MUL  = T_BX + 1;
    localparam int T_MQ   = T_MUL + M_NW;
    localparam int T_LQ   = 1 + LN_NW;
    localparam int LAT    = T_MQ + 3;

    logic [31:0] r_cfg [pff_pkg::NUM_REGS];
    logic [LAT-1:0] r_vld;
    logic w_en;
    logic w_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < pff_pkg::NUM_REGS; k++) begin
                r_cfg[k] <= '0;
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign w_en          = !r_vld[LAT-1] || m_axis_tready;
    assign w_acc         = s_axis_tvalid && w_en;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], w_acc};
        end
    end

    logic [15:0] w_px, w_py, w_ox, w_oy;
    logic [31:0] w_goal, w_g, w_lg;
    logic [15:0] w_refx, w_refy;
    logic [16:0] w_dx, w_dy;
    logic [16:0] w_dl [4];
    logic        w_bnd, w_pt, w_neg;
    pff_pkg::t_flags n_flags;
    pff_pkg::t_mulop n_mul;

    assign w_px = s_axis_tdata[15:0];
    assign w_py = s_axis_tdata[31:16];
    assign w_ox = s_axis_tdata[47:32];
    assign w_oy = s_axis_tdata[63:48];
    assign w_bnd = (s_axis_tuser == pff_pkg::ACT_LINES_RIGHT)
                || (s_axis_tuser == pff_pkg::ACT_LINES_LEFT);
    assign w_neg = (s_axis_tuser == pff_pkg::ACT_RIVAL_ATTRACT)
                || (s_axis_tuser == pff_pkg::ACT_BALL_ATTRACT);
    assign w_pt  = w_neg || (s_axis_tuser == pff_pkg::ACT_RIVAL_REPEL);
    assign w_goal = (s_axis_tuser == pff_pkg::ACT_LINES_RIGHT)
                  ? r_cfg[pff_pkg::REG_RIGHT_GOAL] : r_cfg[pff_pkg::REG_LEFT_GOAL];
    assign w_refx = w_bnd ? w_goal[31:16] : w_ox;
    assign w_refy = w_bnd ? w_goal[15:0]  : w_oy;
    assign w_dx = {w_px[15], w_px} - {w_refx[15], w_refx};
    assign w_dy = {w_py[15], w_py} - {w_refy[15], w_refy};
    assign w_lg = r_cfg[pff_pkg::REG_LINE_GAIN];
    assign w_dl[0] = {w_px[15], w_px}
                   - {r_cfg[pff_pkg::REG_LINES_X][31], r_cfg[pff_pkg::REG_LINES_X][31:16]};
    assign w_dl[1] = {w_px[15], w_px}
                   - {r_cfg[pff_pkg::REG_LINES_X][15], r_cfg[pff_pkg::REG_LINES_X][15:0]};
    assign w_dl[2] = {w_py[15], w_py}
                   - {r_cfg[pff_pkg::REG_LINES_Y][31], r_cfg[pff_pkg::REG_LINES_Y][31:16]};
    assign w_dl[3] = {w_py[15], w_py}
                   - {r_cfg[pff_pkg::REG_LINES_Y][15], r_cfg[pff_pkg::REG_LINES_Y][15:0]};
    assign w_g = w_bnd ? r_cfg[pff_pkg::REG_GOAL_GAIN]
               : ((s_axis_tuser == pff_pkg::ACT_BALL_ATTRACT)
                  ? r_cfg[pff_pkg::REG_BALL_GAIN] : r_cfg[pff_pkg::REG_RIVAL_GAIN]);

    always_comb begin
        n_flags.main_en = w_bnd ? ((w_px != '0) && (w_py != '0)
                                   && ((w_dx != '0) || (w_dy != '0)))
                                : (w_pt && (w_dx != '0) && (w_dy != '0));
        n_flags.sgn_x = w_g[31] ^ w_dx[16] ^ w_neg;
        n_flags.sgn_y = w_g[31] ^ w_dy[16] ^ w_neg;
        for (int k = 0; k < 4; k++) begin
            n_flags.line_en[k]  = w_bnd && (w_dl[k] != '0);
            n_flags.line_sgn[k] = w_lg[31] ^ w_dl[k][16];
        end
        n_mul.pt   = w_pt;
        n_mul.gmag = pff_pkg::mag32(w_g);
        n_mul.ax   = pff_pkg::mag17(w_dx);
        n_mul.ay   = pff_pkg::mag17(w_dy);
    end

    pff_pkg::t_flags r1_flags;
    pff_pkg::t_mulop r1_mul;
    logic [LN_NW-1:0] r1_lnum;
    logic [15:0]      r1_lmag [4];
    logic [31:0]      r2_sqx, r2_sqy;
    logic [15:0]      r2_ax, r2_ay, r3_ax, r3_ay;
    logic [S_W-1:0]   r3_s;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_flags <= n_flags;
            r1_mul   <= n_mul;
            r1_lnum  <= {pff_pkg::mag32(w_lg), 8'd0};
            for (int k = 0; k < 4; k++) begin
                r1_lmag[k] <= pff_pkg::mag17(w_dl[k]);
            end
            r2_sqx <= r1_mul.ax * r1_mul.ax;
            r2_sqy <= r1_mul.ay * r1_mul.ay;
            r2_ax  <= r1_mul.ax;
            r2_ay  <= r1_mul.ay;
            r3_s   <= {1'b0, r2_sqx} + {1'b0, r2_sqy};
            r3_ax  <= r2_ax;
            r3_ay  <= r2_ay;
        end
    end

    logic [LN_NW-1:0] w_lq [4];
    for (genvar k = 0; k < 4; k++) begin : g_line
        pff_div #(.NW(LN_NW), .DW(16), .QW(LN_NW)) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r1_lnum),
            .i_den (r1_lmag[k]),
            .o_quo (w_lq[k])
        );
    end

    logic [ROOT_W-1:0] w_root, w_r16;
    logic [BX_QW-1:0]  w_bqx, w_bqy;

    pff_sqrt #(.IW(2 * ROOT_W)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  ({1'b0, r3_s, 16'd0}),
        .o_root (w_root)
    );

    pff_delay #(.W(ROOT_W), .D(T_BX - T_ROOT)) u_root_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_root),
        .o_q   (w_r16)
    );

    pff_div #(.NW(BX_NW), .DW(S_W), .QW(BX_QW)) u_bx (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num ({r3_ax, 31'd0}),
        .i_den (r3_s),
        .o_quo (w_bqx)
    );

    pff_div #(.NW(BX_NW), .DW(S_W), .QW(BX_QW)) u_by (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num ({r3_ay, 31'd0}),
        .i_den (r3_s),
        .o_quo (w_bqy)
    );

    pff_pkg::t_mulop w_mul_a;
    pff_delay #(.W($bits(pff_pkg::t_mulop)), .D(T_BX - 1)) u_mul_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r1_mul),
        .o_q   (w_mul_a)
    );

    logic [31:0] w_opx, w_opy;
    logic [63:0] w_prx, w_pry;
    logic [M_NW-1:0]   r35_mx, r35_my;
    logic [ROOT_W-1:0] r35_r16;
    logic              r35_pt;

    assign w_opx = w_mul_a.pt ? {1'b0, w_bqx} : {16'd0, w_mul_a.ax};
    assign w_opy = w_mul_a.pt ? {1'b0, w_bqy} : {16'd0, w_mul_a.ay};
    assign w_prx = w_mul_a.gmag * w_opx;
    assign w_pry = w_mul_a.gmag * w_opy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r35_mx  <= w_prx[M_NW-1:0];
            r35_my  <= w_pry[M_NW-1:0];
            r35_r16 <= w_r16;
            r35_pt  <= w_mul_a.pt;
        end
    end

    logic [M_NW-1:0] w_numx, w_numy, w_mqx, w_mqy;
    logic [M_DW-1:0] w_den;

    assign w_numx = r35_pt ? r35_mx : {r35_mx[M_NW-9:0], 8'd0};
    assign w_numy = r35_pt ? r35_my : {r35_my[M_NW-9:0], 8'd0};
    assign w_den  = r35_pt ? {r35_r16, 7'd0} : {7'd0, r35_r16};

    pff_div #(.NW(M_NW), .DW(M_DW), .QW(M_NW)) u_mdx (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_numx),
        .i_den (w_den),
        .o_quo (w_mqx)
    );

    pff_div #(.NW(M_NW), .DW(M_DW), .QW(M_NW)) u_mdy (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_numy),
        .i_den (w_den),
        .o_quo (w_mqy)
    );

    logic [4*LN_NW-1:0] w_lq_a;
    pff_delay #(.W(4 * LN_NW), .D(T_MQ - T_LQ)) u_line_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({w_lq[3], w_lq[2], w_lq[1], w_lq[0]}),
        .o_q   (w_lq_a)
    );

    pff_pkg::t_flags w_flg;
    pff_delay #(.W($bits(pff_pkg::t_flags)), .D(T_MQ - 1)) u_flag_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r1_flags),
        .o_q   (w_flg)
    );

    logic [63:0] r99_mx, r99_my;
    logic [63:0] r99_l [4];
    logic [63:0] r100_fx, r100_fy;
    logic [31:0] n_out_fx, n_out_fy;
    logic        n_sat_x, n_sat_y;
    logic [31:0] r_out_fx, r_out_fy;
    logic        r_out_sat;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r99_mx <= pff_pkg::signed_term(w_flg.main_en, w_flg.sgn_x, w_mqx);
            r99_my <= pff_pkg::signed_term(w_flg.main_en, w_flg.sgn_y, w_mqy);
            for (int k = 0; k < 4; k++) begin
                r99_l[k] <= pff_pkg::signed_term(w_flg.line_en[k], w_flg.line_sgn[k],
                                                 63'(w_lq_a[k*LN_NW +: LN_NW]));
            end
            r100_fx <= r99_mx + r99_l[0] + r99_l[1];
            r100_fy <= r99_my + r99_l[2] + r99_l[3];
        end
    end

    always_comb begin
        n_sat_x  = (r100_fx[63:31] != '0) && (r100_fx[63:31] != '1);
        n_sat_y  = (r100_fy[63:31] != '0) && (r100_fy[63:31] != '1);
        n_out_fx = n_sat_x ? (r100_fx[63] ? 32'h8000_0000 : 32'h7FFF_FFFF) : r100_fx[31:0];
        n_out_fy = n_sat_y ? (r100_fy[63] ? 32'h8000_0000 : 32'h7FFF_FFFF) : r100_fy[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_fx  <= n_out_fx;
            r_out_fy  <= n_out_fy;
            r_out_sat <= n_sat_x || n_sat_y;
        end
    end

    assign m_axis_tdata = {r_out_fy, r_out_fx};
    assign m_axis_tuser = r_out_sat;

`ifndef SYNTHESIS
    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while the output beat is stalled");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[0])
        else $error("accepted beat did not enter the pipeline");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (r_out_fx == 32'h7FFF_FFFF) || (r_out_fx == 32'h8000_0000)
            || (r_out_fy == 32'h7FFF_FFFF) || (r_out_fy == 32'h8000_0000))
        else $error("saturation flag set without a clipped component");
`endif
endmodule

/* src/pff_delay.sv */
// Enabled shift line that delays a word by a fixed number of pipeline steps.
module pff_delay #(
    parameter int W = 8,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_tap [D];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < D; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[D-1];
endmodule

/* src/pff_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module pff_div #(
    parameter int NW = 40,
    parameter int DW = 16,
    parameter int QW = 40
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);
    logic [DW-1:0] r_rem [QW-1];
    logic [DW-1:0] r_den [QW-1];
    logic [QW-1:0] r_sh  [QW];
    logic [DW-1:0] w_init;

    if (NW > QW) begin : g_hi
        assign w_init = DW'(i_num[NW-1:QW]);
    end else begin : g_nohi
        assign w_init = '0;
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] sh_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] n_rem;
        logic [QW-1:0] n_sh;

        if (k == 0) begin : g_first
            assign rem_in = w_init;
            assign den_in = i_den;
            assign sh_in  = i_num[QW-1:0];
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign sh_in  = r_sh[k-1];
        end

        assign trial = {rem_in, sh_in[QW-1]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = (trial >= {1'b0, den_in});
        assign n_rem = ge ? diff[DW-1:0] : trial[DW-1:0];
        assign n_sh  = {sh_in[QW-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sh[k] <= n_sh;
            end
        end

        if (k < QW - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_den[k] <= den_in;
                end
            end
        end
    end

    assign o_quo = r_sh[QW-1];
endmodule

/* src/pff_sqrt.sv */
// Pipelined digit-by-digit integer square root, one root bit per stage.
module pff_sqrt #(
    parameter int IW = 50
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [IW-1:0]   i_rad,
    output logic [IW/2-1:0] o_root
);
    localparam int OW = IW / 2;
    localparam int RW = OW + 2;

    logic [RW-1:0] r_rem  [OW-1];
    logic [IW-1:0] r_rad  [OW-1];
    logic [OW-1:0] r_root [OW];

    for (genvar k = 0; k < OW; k++) begin : g_step
        logic [RW-1:0] rem_in;
        logic [IW-1:0] rad_in;
        logic [OW-1:0] root_in;
        logic [RW-1:0] t;
        logic [RW-1:0] trial;
        logic          ge;
        logic [RW-1:0] n_rem;
        logic [OW-1:0] n_root;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign rad_in  = i_rad;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign rad_in  = r_rad[k-1];
            assign root_in = r_root[k-1];
        end

        assign t      = {rem_in[RW-3:0], rad_in[IW-1:IW-2]};
        assign trial  = {root_in, 2'b01};
        assign ge     = (t >= trial);
        assign n_rem  = ge ? (t - trial) : t;
        assign n_root = {root_in[OW-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= n_root;
            end
        end

        if (k < OW - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_rad[k] <= {rad_in[IW-3:0], 2'b00};
                end
            end
        end
    end

    assign o_root = r_root[OW-1];
endmodule
